// File: rtl/core/accumulator_machine_execute_defines.svh
// assertion macros for the accumulator machine execute block
`ifndef ACCUMULATOR_MACHINE_EXECUTE_DEFINES_SVH
`define ACCUMULATOR_MACHINE_EXECUTE_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define AMX_CHECK_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define AMX_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/amx_pkg.sv
// shared types, codes and microcode table of the accumulator machine
package amx_pkg;

    localparam int WORD_BITS = 32;
    localparam int ADDR_W    = 10;
    localparam int MEM_WORDS = 1 << ADDR_W;
    localparam int ITER_W    = $clog2(WORD_BITS);
    localparam int UPC_W     = 5;
    localparam int OP_W      = 5;

    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(WORD_BITS - 1);

    typedef logic [WORD_BITS-1:0] word_t;

    // instruction op codes
    localparam logic [OP_W-1:0] OP_NOP    = 5'd0;
    localparam logic [OP_W-1:0] OP_ACC_MQ = 5'd1;
    localparam logic [OP_W-1:0] OP_MQ_MEM = 5'd2;
    localparam logic [OP_W-1:0] OP_STORE  = 5'd3;
    localparam logic [OP_W-1:0] OP_LD     = 5'd4;
    localparam logic [OP_W-1:0] OP_LDN    = 5'd5;
    localparam logic [OP_W-1:0] OP_LDA    = 5'd6;
    localparam logic [OP_W-1:0] OP_LDNA   = 5'd7;
    localparam logic [OP_W-1:0] OP_JMP    = 5'd8;
    localparam logic [OP_W-1:0] OP_JMPP   = 5'd9;
    localparam logic [OP_W-1:0] OP_ADD    = 5'd10;
    localparam logic [OP_W-1:0] OP_ADDA   = 5'd11;
    localparam logic [OP_W-1:0] OP_SUB    = 5'd12;
    localparam logic [OP_W-1:0] OP_SUBA   = 5'd13;
    localparam logic [OP_W-1:0] OP_MUL    = 5'd14;
    localparam logic [OP_W-1:0] OP_DIV    = 5'd15;
    localparam logic [OP_W-1:0] OP_LSH    = 5'd16;
    localparam logic [OP_W-1:0] OP_RSH    = 5'd17;
    localparam logic [OP_W-1:0] OP_START  = 5'd18;
    localparam logic [OP_W-1:0] OP_HALT   = 5'd19;
    localparam logic [OP_W-1:0] OP_WRITE  = 5'd20;

    // datapath micro-operations
    localparam logic [4:0] U_NONE     = 5'd0;
    localparam logic [4:0] U_ACC_MQ   = 5'd1;
    localparam logic [4:0] U_MQ_MEM   = 5'd2;
    localparam logic [4:0] U_STORE    = 5'd3;
    localparam logic [4:0] U_LD       = 5'd4;
    localparam logic [4:0] U_LDN      = 5'd5;
    localparam logic [4:0] U_LDA      = 5'd6;
    localparam logic [4:0] U_LDNA     = 5'd7;
    localparam logic [4:0] U_JMP      = 5'd8;
    localparam logic [4:0] U_JMPP     = 5'd9;
    localparam logic [4:0] U_ADD      = 5'd10;
    localparam logic [4:0] U_ADDA     = 5'd11;
    localparam logic [4:0] U_SUB      = 5'd12;
    localparam logic [4:0] U_SUBA     = 5'd13;
    localparam logic [4:0] U_MUL_INIT = 5'd14;
    localparam logic [4:0] U_MUL_STEP = 5'd15;
    localparam logic [4:0] U_MUL_FIN  = 5'd16;
    localparam logic [4:0] U_DIV_INIT = 5'd17;
    localparam logic [4:0] U_DIV_STEP = 5'd18;
    localparam logic [4:0] U_DIV_FIX  = 5'd19;
    localparam logic [4:0] U_DIV_FLT  = 5'd20;
    localparam logic [4:0] U_LSH      = 5'd21;
    localparam logic [4:0] U_RSH      = 5'd22;
    localparam logic [4:0] U_START    = 5'd23;
    localparam logic [4:0] U_HALT     = 5'd24;
    localparam logic [4:0] U_WRITE    = 5'd25;

    // sequencing codes
    localparam logic [2:0] SQ_NEXT     = 3'd0;
    localparam logic [2:0] SQ_DISPATCH = 3'd1;
    localparam logic [2:0] SQ_LOOP     = 3'd2;
    localparam logic [2:0] SQ_JZ       = 3'd3;
    localparam logic [2:0] SQ_END      = 3'd4;

    // microcode addresses
    localparam logic [UPC_W-1:0] E_DISPATCH = 5'd0;
    localparam logic [UPC_W-1:0] E_NOP      = 5'd1;
    localparam logic [UPC_W-1:0] E_HOLD     = 5'd2;
    localparam logic [UPC_W-1:0] E_ACC_MQ   = 5'd3;
    localparam logic [UPC_W-1:0] E_MQ_MEM   = 5'd4;
    localparam logic [UPC_W-1:0] E_STORE    = 5'd5;
    localparam logic [UPC_W-1:0] E_LD       = 5'd6;
    localparam logic [UPC_W-1:0] E_LDN      = 5'd7;
    localparam logic [UPC_W-1:0] E_LDA      = 5'd8;
    localparam logic [UPC_W-1:0] E_LDNA     = 5'd9;
    localparam logic [UPC_W-1:0] E_JMP      = 5'd10;
    localparam logic [UPC_W-1:0] E_JMPP     = 5'd11;
    localparam logic [UPC_W-1:0] E_ADD      = 5'd12;
    localparam logic [UPC_W-1:0] E_ADDA     = 5'd13;
    localparam logic [UPC_W-1:0] E_SUB      = 5'd14;
    localparam logic [UPC_W-1:0] E_SUBA     = 5'd15;
    localparam logic [UPC_W-1:0] E_MUL_INIT = 5'd16;
    localparam logic [UPC_W-1:0] E_MUL_STEP = 5'd17;
    localparam logic [UPC_W-1:0] E_MUL_FIN  = 5'd18;
    localparam logic [UPC_W-1:0] E_DIV_INIT = 5'd19;
    localparam logic [UPC_W-1:0] E_DIV_STEP = 5'd20;
    localparam logic [UPC_W-1:0] E_DIV_FIX  = 5'd21;
    localparam logic [UPC_W-1:0] E_DIV_FLT  = 5'd22;
    localparam logic [UPC_W-1:0] E_LSH      = 5'd23;
    localparam logic [UPC_W-1:0] E_RSH      = 5'd24;
    localparam logic [UPC_W-1:0] E_START    = 5'd25;
    localparam logic [UPC_W-1:0] E_HALT     = 5'd26;
    localparam logic [UPC_W-1:0] E_WRITE    = 5'd27;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [ADDR_W-1:0]        addr;
        logic signed [WORD_BITS-1:0] data;
    } amx_cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0]           next_pc;
        logic signed [WORD_BITS-1:0] acc_value;
        logic signed [WORD_BITS-1:0] mq_value;
        logic                        halted;
        logic                        divide_fault;
    } amx_res_t;

    typedef struct packed {
        logic [4:0]       dp_op;
        logic             pc_inc;
        logic             emit;
        logic [2:0]       seq;
        logic [UPC_W-1:0] target;
    } amx_uword_t;

    typedef struct packed {
        logic       step;
        amx_uword_t uw;
    } amx_ctl_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            halted;
        logic            mem_zero;
    } amx_stat_t;

    function automatic word_t w_neg(input word_t x);
        return word_t'(0) - x;
    endfunction

    function automatic word_t w_abs(input word_t x);
        return x[WORD_BITS-1] ? w_neg(x) : x;
    endfunction

    function automatic amx_uword_t mk_uw(input logic [4:0] dp_op, input logic pc_inc,
                                         input logic emit, input logic [2:0] seq,
                                         input logic [UPC_W-1:0] target);
        amx_uword_t w;
        w.dp_op  = dp_op;
        w.pc_inc = pc_inc;
        w.emit   = emit;
        w.seq    = seq;
        w.target = target;
        return w;
    endfunction

    // microcode store
    function automatic amx_uword_t amx_rom(input logic [UPC_W-1:0] upc);
        amx_uword_t w;
        case (upc)
            E_DISPATCH: w = mk_uw(U_NONE,     1'b0, 1'b0, SQ_DISPATCH, E_DISPATCH);
            E_NOP:      w = mk_uw(U_NONE,     1'b1, 1'b1, SQ_END,      E_DISPATCH);
            E_HOLD:     w = mk_uw(U_NONE,     1'b0, 1'b1, SQ_END,      E_DISPATCH);
            E_ACC_MQ:   w = mk_uw(U_ACC_MQ,   1'b1, 1'b1, SQ_END,      E_DISPATCH);
            E_MQ_MEM:   w = mk_uw(U_MQ_MEM,   1'b1, 1'b1, SQ_END,      E_DISPATCH);
            E_STORE:    w = mk_uw(U_STORE,    1'b1, 1'b1, SQ_END,      E_DISPATCH);
            E_LD:       w = mk_uw(U_LD,       1'b1, 1'b1, SQ_END,      E_DISPATCH);
            E_LDN:      w = mk_uw(U_LDN,      1'b1, 1'b1, SQ_END,      E_DISPATCH);
            E_LDA:      w = mk_uw(U_LDA,      1'b1, 1'b1, SQ_END,      E_DISPATCH);
            E_LDNA:     w = mk_uw(U_LDNA,     1'b1, 1'b1, SQ_END,      E_DISPATCH);
            E_JMP:      w = mk_uw(U_JMP,      1'b0, 1'b1, SQ_END,      E_DISPATCH);
            E_JMPP:     w = mk_uw(U_JMPP,     1'b0, 1'b1, SQ_END,      E_DISPATCH);
            E_ADD:      w = mk_uw(U_ADD,      1'b1, 1'b1, SQ_END,      E_DISPATCH);
            E_ADDA:     w = mk_uw(U_ADDA,     1'b1, 1'b1, SQ_END,      E_DISPATCH);
            E_SUB:      w = mk_uw(U_SUB,      1'b1, 1'b1, SQ_END,      E_DISPATCH);
            E_SUBA:     w = mk_uw(U_SUBA,     1'b1, 1'b1, SQ_END,      E_DISPATCH);
            E_MUL_INIT: w = mk_uw(U_MUL_INIT, 1'b0, 1'b0, SQ_NEXT,     E_DISPATCH);
            E_MUL_STEP: w = mk_uw(U_MUL_STEP, 1'b0, 1'b0, SQ_LOOP,     E_DISPATCH);
            E_MUL_FIN:  w = mk_uw(U_MUL_FIN,  1'b1, 1'b1, SQ_END,      E_DISPATCH);
            E_DIV_INIT: w = mk_uw(U_DIV_INIT, 1'b0, 1'b0, SQ_JZ,       E_DIV_FLT);
            E_DIV_STEP: w = mk_uw(U_DIV_STEP, 1'b0, 1'b0, SQ_LOOP,     E_DISPATCH);
            E_DIV_FIX:  w = mk_uw(U_DIV_FIX,  1'b1, 1'b1, SQ_END,      E_DISPATCH);
            E_DIV_FLT:  w = mk_uw(U_DIV_FLT,  1'b1, 1'b1, SQ_END,      E_DISPATCH);
            E_LSH:      w = mk_uw(U_LSH,      1'b1, 1'b1, SQ_END,      E_DISPATCH);
            E_RSH:      w = mk_uw(U_RSH,      1'b1, 1'b1, SQ_END,      E_DISPATCH);
            E_START:    w = mk_uw(U_START,    1'b0, 1'b1, SQ_END,      E_DISPATCH);
            E_HALT:     w = mk_uw(U_HALT,     1'b1, 1'b1, SQ_END,      E_DISPATCH);
            E_WRITE:    w = mk_uw(U_WRITE,    1'b0, 1'b1, SQ_END,      E_DISPATCH);
            default:    w = mk_uw(U_NONE,     1'b0, 1'b1, SQ_END,      E_DISPATCH);
        endcase
        return w;
    endfunction

    // entry point of each instruction; start and word write run even when halted
    function automatic logic [UPC_W-1:0] amx_entry(input logic [OP_W-1:0] op,
                                                   input logic halted);
        logic [UPC_W-1:0] e;
        e = E_NOP;
        if (op == OP_START) begin
            e = E_START;
        end else if (op == OP_WRITE) begin
            e = E_WRITE;
        end else if (halted) begin
            e = E_HOLD;
        end else begin
            case (op)
                OP_ACC_MQ: e = E_ACC_MQ;
                OP_MQ_MEM: e = E_MQ_MEM;
                OP_STORE:  e = E_STORE;
                OP_LD:     e = E_LD;
                OP_LDN:    e = E_LDN;
                OP_LDA:    e = E_LDA;
                OP_LDNA:   e = E_LDNA;
                OP_JMP:    e = E_JMP;
                OP_JMPP:   e = E_JMPP;
                OP_ADD:    e = E_ADD;
                OP_ADDA:   e = E_ADDA;
                OP_SUB:    e = E_SUB;
                OP_SUBA:   e = E_SUBA;
                OP_MUL:    e = E_MUL_INIT;
                OP_DIV:    e = E_DIV_INIT;
                OP_LSH:    e = E_LSH;
                OP_RSH:    e = E_RSH;
                OP_HALT:   e = E_HALT;
                default:   e = E_NOP;
            endcase
        end
        return e;
    endfunction

endpackage

// File: rtl/core/amx_seq.sv
// microcode sequencer: step counter, loop counter and dispatch
module amx_seq
    import amx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      out_block,
    input  amx_stat_t stat,
    output amx_ctl_t  ctl,
    output logic      busy
);

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_RUN  = 1'b1;

    logic [0:0]        state_reg, state_next;
    logic [UPC_W-1:0]  upc_reg, upc_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    amx_uword_t        uw;
    logic              step;

    always_comb
    begin
        uw   = amx_rom(upc_reg);
        busy = (state_reg == ST_RUN);
        // a word that emits waits while the output register is still held
        step = busy && !(uw.emit && out_block);

        state_next = state_reg;
        upc_next   = upc_reg;
        iter_next  = iter_reg;

        if (start)
        begin
            state_next = ST_RUN;
            upc_next   = E_DISPATCH;
            iter_next  = '0;
        end
        else if (step)
        begin
            case (uw.seq)
                SQ_NEXT:     upc_next = upc_reg + 1'b1;
                SQ_DISPATCH: upc_next = amx_entry(stat.op, stat.halted);
                SQ_LOOP:
                begin
                    if (iter_reg == ITER_LAST)
                    begin
                        iter_next = '0;
                        upc_next  = upc_reg + 1'b1;
                    end
                    else
                    begin
                        iter_next = iter_reg + 1'b1;
                    end
                end
                SQ_JZ:       upc_next = stat.mem_zero ? uw.target : upc_reg + 1'b1;
                SQ_END:      state_next = ST_IDLE;
                default:     state_next = ST_IDLE;
            endcase
        end
    end

    assign ctl.step = step;
    assign ctl.uw   = uw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            upc_reg   <= E_DISPATCH;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            upc_reg   <= upc_next;
            iter_reg  <= iter_next;
        end
    end

endmodule

// File: rtl/core/amx_dpath.sv
// datapath: machine registers, shift-add multiply, restoring divide and word memory
module amx_dpath
    import amx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  amx_cmd_t  cmd,
    input  amx_ctl_t  ctl,
    output amx_res_t  res,
    output amx_stat_t stat,
    output logic      clearing
);

    logic [WORD_BITS-1:0] mem [MEM_WORDS];

    logic [OP_W-1:0]      op_reg;
    logic [ADDR_W-1:0]    addr_reg;
    word_t                data_reg;
    word_t                mem_q_reg;
    word_t                acc_reg, acc_next;
    word_t                mq_reg, mq_next;
    logic [ADDR_W-1:0]    pc_reg, pc_next;
    logic                 halt_reg, halt_next;
    logic                 fault_reg, fault_next;
    word_t                ta_reg, ta_next;
    word_t                tb_reg, tb_next;
    word_t                tc_reg, tc_next;
    logic [ADDR_W:0]      clr_reg;

    word_t                m_abs;
    word_t                acc_abs;
    word_t                rem_sh;
    logic [WORD_BITS:0]   diff;
    logic                 mem_rd;
    logic                 mem_we;
    logic [ADDR_W-1:0]    wr_addr;
    word_t                wr_data;

    assign clearing = !clr_reg[ADDR_W];
    assign m_abs    = w_abs(mem_q_reg);
    assign acc_abs  = w_abs(acc_reg);
    assign rem_sh   = {ta_reg[WORD_BITS-2:0], tc_reg[WORD_BITS-1]};
    assign diff     = {1'b0, rem_sh} - {1'b0, tb_reg};

    always_comb
    begin
        acc_next   = acc_reg;
        mq_next    = mq_reg;
        pc_next    = pc_reg;
        halt_next  = halt_reg;
        fault_next = accept ? 1'b0 : fault_reg;
        ta_next    = ta_reg;
        tb_next    = tb_reg;
        tc_next    = tc_reg;

        if (ctl.step)
        begin
            if (ctl.uw.pc_inc)
            begin
                pc_next = pc_reg + 1'b1;
            end
            case (ctl.uw.dp_op)
                U_ACC_MQ: acc_next = mq_reg;
                U_MQ_MEM: mq_next  = mem_q_reg;
                U_LD:     acc_next = mem_q_reg;
                U_LDN:    acc_next = w_neg(mem_q_reg);
                U_LDA:    acc_next = m_abs;
                U_LDNA:   acc_next = w_neg(m_abs);
                U_JMP:    pc_next  = addr_reg;
                U_JMPP:   pc_next  = acc_reg[WORD_BITS-1] ? pc_reg + 1'b1 : addr_reg;
                U_ADD:    acc_next = acc_reg + mem_q_reg;
                U_ADDA:   acc_next = acc_reg + m_abs;
                U_SUB:    acc_next = acc_reg - mem_q_reg;
                U_SUBA:   acc_next = acc_reg - m_abs;
                U_MUL_INIT:
                begin
                    ta_next = '0;
                    tb_next = mem_q_reg;
                    tc_next = mq_reg;
                end
                U_MUL_STEP:
                begin
                    if (tc_reg[0])
                    begin
                        ta_next = ta_reg + tb_reg;
                    end
                    tb_next = {tb_reg[WORD_BITS-2:0], 1'b0};
                    tc_next = {1'b0, tc_reg[WORD_BITS-1:1]};
                end
                U_MUL_FIN: acc_next = ta_reg;
                U_DIV_INIT:
                begin
                    ta_next = '0;
                    tb_next = m_abs;
                    tc_next = w_abs(acc_reg);
                end
                U_DIV_STEP:
                begin
                    // one quotient bit per step, partial remainder in ta
                    ta_next = diff[WORD_BITS] ? rem_sh : diff[WORD_BITS-1:0];
                    tc_next = {tc_reg[WORD_BITS-2:0], !diff[WORD_BITS]};
                end
                U_DIV_FIX:
                begin
                    mq_next  = (acc_reg[WORD_BITS-1] ^ mem_q_reg[WORD_BITS-1]) ?
                               w_neg(tc_reg) : tc_reg;
                    acc_next = acc_reg[WORD_BITS-1] ? w_neg(ta_reg) : ta_reg;
                end
                U_DIV_FLT: fault_next = 1'b1;
                U_LSH:     acc_next = {acc_reg[WORD_BITS-2:0], 1'b0};
                U_RSH:     acc_next = acc_reg[WORD_BITS-1] ?
                                      w_neg({1'b0, acc_abs[WORD_BITS-1:1]}) :
                                      {1'b0, acc_reg[WORD_BITS-1:1]};
                U_START:   pc_next   = addr_reg;
                U_HALT:    halt_next = 1'b1;
                default:   ;
            endcase
        end
    end

    // memory ports; the clearing pass owns the write port after reset
    always_comb
    begin
        mem_rd  = ctl.step && (ctl.uw.seq == SQ_DISPATCH);
        mem_we  = clearing ||
                  (ctl.step && ((ctl.uw.dp_op == U_STORE) || (ctl.uw.dp_op == U_WRITE)));
        wr_addr = clearing ? clr_reg[ADDR_W-1:0] : addr_reg;
        wr_data = clearing ? '0 : ((ctl.uw.dp_op == U_WRITE) ? data_reg : acc_reg);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_rd)
        begin
            mem_q_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= cmd.op;
            addr_reg <= cmd.addr;
            data_reg <= word_t'(cmd.data);
        end
        ta_reg <= ta_next;
        tb_reg <= tb_next;
        tc_reg <= tc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            mq_reg    <= '0;
            pc_reg    <= '0;
            halt_reg  <= 1'b0;
            fault_reg <= 1'b0;
            clr_reg   <= '0;
        end
        else
        begin
            acc_reg   <= acc_next;
            mq_reg    <= mq_next;
            pc_reg    <= pc_next;
            halt_reg  <= halt_next;
            fault_reg <= fault_next;
            if (clearing)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    assign res.next_pc      = pc_next;
    assign res.acc_value    = acc_next;
    assign res.mq_value     = mq_next;
    assign res.halted       = halt_next;
    assign res.divide_fault = fault_next;

    assign stat.op       = op_reg;
    assign stat.halted   = halt_reg;
    assign stat.mem_zero = (mem_q_reg == '0);

endmodule

// File: rtl/core/accumulator_machine_execute.sv
// accumulator machine execute block: microcoded sequencer, datapath and result register
// sequence: a dispatch word reads the memory operand, then the op's words run and the last
//   one loads the result register; mul and div run the 32-step shift-add and
//   restoring-divide loops, and a zero divisor skips to the fault word
// a new item is taken only once the last one has loaded its result; that word waits while the output is held
// reset: registers cleared, then a pass zeroes all 1024 memory words before any item
`include "accumulator_machine_execute_defines.svh"

module accumulator_machine_execute
    import amx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  amx_cmd_t cmd,
    output logic     res_valid,
    input  logic     res_stall,
    output amx_res_t res
);

    amx_ctl_t  ctl;
    amx_stat_t stat;
    amx_res_t  dp_res;
    logic      busy;
    logic      clearing;
    logic      accept;
    logic      out_block;
    logic      emit;
    logic      res_valid_reg, res_valid_next;
    amx_res_t  res_reg;

    assign cmd_stall = busy || clearing;
    assign accept    = cmd_valid && !cmd_stall;
    assign out_block = res_valid_reg && res_stall;
    assign emit      = ctl.step && ctl.uw.emit;

    amx_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .out_block (out_block),
        .stat      (stat),
        .ctl       (ctl),
        .busy      (busy)
    );

    amx_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .cmd      (cmd),
        .ctl      (ctl),
        .res      (dp_res),
        .stat     (stat),
        .clearing (clearing)
    );

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg <= dp_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `AMX_CHECK_NEXT(a_accept_starts, accept, busy, "accepted item did not start the sequencer")
    `AMX_CHECK_NOW(a_emit_in_run, emit, busy && !clearing, "result emitted outside a run")
    `AMX_CHECK_NEXT(a_clear_once, !clearing, !clearing, "memory clearing pass restarted")
    `AMX_CHECK_NEXT(a_halt_sticky, res_valid && res.halted, !res_valid || res.halted, "halt flag fell")

endmodule
